// ----- rtl/u8u16_pkg.sv -----
// Shared types and constants for the UTF-8 to UTF-16LE transcoder.
// No dependencies; imported by every module of the block.
package u8u16_pkg;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_UNIT = 2'd0,
        KIND_DONE = 2'd1,
        KIND_BAD  = 2'd2,
        KIND_SURR = 2'd3
    } kind_t;

    // One input request: a UTF-8 byte and the end-of-string flag
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_string;
    } in_item_t;

    // One result request
    typedef struct packed {
        logic [15:0] code_unit;
        kind_t       kind;
        logic        run_last;
    } out_item_t;

    // Maximum results caused by one byte: surrogate pair plus done
    localparam int MAX_RES = 3;
    localparam int CNT_W   = $clog2(MAX_RES + 1);

    // All results caused by one byte, slot 0 first
    typedef struct packed {
        logic [CNT_W-1:0]            cnt;
        out_item_t [MAX_RES-1:0]     res;
    } res_bundle_t;

    localparam logic [15:0] HI_SURR_BASE = 16'hD800;
    localparam logic [15:0] LO_SURR_BASE = 16'hDC00;
    localparam logic [20:0] SURR_FIRST   = 21'h00D800;
    localparam logic [20:0] SURR_LAST    = 21'h00DFFF;
    localparam logic [20:0] MIN_2BYTE    = 21'h000080;
    localparam logic [20:0] MIN_3BYTE    = 21'h000800;
    localparam logic [20:0] MIN_4BYTE    = 21'h010000;
    localparam logic [20:0] MAX_POINT    = 21'h10FFFF;
    localparam logic [20:0] BMP_LAST     = 21'h00FFFF;
    localparam logic [9:0]  PLANE_OFFSET = 10'h040;

endpackage

// ----- rtl/u8u16_decode.sv -----
// Sequence state and per-byte decode for the UTF-8 to UTF-16LE transcoder.
// Depends on u8u16_pkg; produces the full result bundle for one byte.
module u8u16_decode (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   take,
    input  u8u16_pkg::in_item_t    item,
    output u8u16_pkg::res_bundle_t bundle
);
    import u8u16_pkg::*;

    logic [20:0] point_reg, point_next;
    logic [1:0]  expect_reg, expect_next;
    logic [2:0]  seq_len_reg, seq_len_next;
    logic        failed_reg, failed_next;

    logic [7:0]  c;
    logic        eos;
    logic        ending;
    logic [20:0] point_acc;
    logic [1:0]  expect_dec;
    logic        overlong;
    logic [9:0]  hi_bits;
    logic [CNT_W-1:0] cnt;
    out_item_t [MAX_RES-1:0] res;

    assign c      = item.in_byte;
    assign eos    = item.end_of_string;
    assign ending = eos || (c == 8'd0);

    // Continuation accumulate and range checks on the completed point
    assign point_acc  = {point_reg[14:0], c[5:0]};
    assign expect_dec = expect_reg - 2'd1;
    assign hi_bits    = point_acc[19:10] - PLANE_OFFSET;

    always_comb
    begin
        case (seq_len_reg)
            3'd2:    overlong = point_acc < MIN_2BYTE;
            3'd3:    overlong = point_acc < MIN_3BYTE;
            default: overlong = (point_acc < MIN_4BYTE) || (point_acc > MAX_POINT);
        endcase
    end

    // Decode: results for this byte and next sequence state
    always_comb
    begin
        point_next   = point_reg;
        expect_next  = expect_reg;
        seq_len_next = seq_len_reg;
        failed_next  = failed_reg;
        cnt          = '0;
        res          = '0;

        if (failed_reg)
        begin
            // discarding the rest of a failed string
            if (ending)
            begin
                point_next   = '0;
                expect_next  = '0;
                seq_len_next = '0;
                failed_next  = 1'b0;
            end
        end
        else if (expect_reg == 2'd0)
        begin
            if (c == 8'd0)
            begin
                res[0].kind  = KIND_DONE;
                cnt          = CNT_W'(1);
                point_next   = '0;
                seq_len_next = '0;
            end
            else if (c[7] == 1'b0)
            begin
                res[0].code_unit = {8'd0, c};
                res[0].kind      = KIND_UNIT;
                cnt              = CNT_W'(1);
                if (eos)
                begin
                    res[1].kind  = KIND_DONE;
                    cnt          = CNT_W'(2);
                    point_next   = '0;
                    seq_len_next = '0;
                end
            end
            else
            begin
                case (c) inside
                    8'b110?????:
                    begin
                        point_next   = {16'd0, c[4:0]};
                        expect_next  = 2'd1;
                        seq_len_next = 3'd2;
                    end
                    8'b1110????:
                    begin
                        point_next   = {17'd0, c[3:0]};
                        expect_next  = 2'd2;
                        seq_len_next = 3'd3;
                    end
                    8'b11110???:
                    begin
                        point_next   = {18'd0, c[2:0]};
                        expect_next  = 2'd3;
                        seq_len_next = 3'd4;
                    end
                    default:
                    begin
                        // stray continuation or five-byte-plus lead
                        res[0].kind = KIND_BAD;
                        cnt         = CNT_W'(1);
                        point_next  = '0;
                        expect_next = '0;
                        seq_len_next = '0;
                        failed_next = !ending;
                    end
                endcase
                if (eos && (cnt == '0))
                begin
                    // lead byte at end of string: truncated
                    res[0].kind  = KIND_BAD;
                    cnt          = CNT_W'(1);
                    point_next   = '0;
                    expect_next  = '0;
                    seq_len_next = '0;
                end
            end
        end
        else
        begin
            if ((c == 8'd0) || (c[7:6] != 2'b10))
            begin
                res[0].kind  = KIND_BAD;
                cnt          = CNT_W'(1);
                point_next   = '0;
                expect_next  = '0;
                seq_len_next = '0;
                failed_next  = !ending;
            end
            else if (expect_dec == 2'd0)
            begin
                point_next   = '0;
                expect_next  = '0;
                seq_len_next = '0;
                if (overlong)
                begin
                    res[0].kind = KIND_BAD;
                    cnt         = CNT_W'(1);
                    failed_next = !eos;
                end
                else if ((point_acc >= SURR_FIRST) && (point_acc <= SURR_LAST))
                begin
                    res[0].kind = KIND_SURR;
                    cnt         = CNT_W'(1);
                    failed_next = !eos;
                end
                else if (point_acc <= BMP_LAST)
                begin
                    res[0].code_unit = point_acc[15:0];
                    res[0].kind      = KIND_UNIT;
                    cnt              = CNT_W'(1);
                    if (eos)
                    begin
                        res[1].kind = KIND_DONE;
                        cnt         = CNT_W'(2);
                    end
                end
                else
                begin
                    // surrogate pair for supplementary planes
                    res[0].code_unit = HI_SURR_BASE | {6'd0, hi_bits};
                    res[0].kind      = KIND_UNIT;
                    res[1].code_unit = LO_SURR_BASE | {6'd0, point_acc[9:0]};
                    res[1].kind      = KIND_UNIT;
                    cnt              = CNT_W'(2);
                    if (eos)
                    begin
                        res[2].kind = KIND_DONE;
                        cnt         = CNT_W'(3);
                    end
                end
            end
            else if (eos)
            begin
                // truncated inside a sequence
                res[0].kind  = KIND_BAD;
                cnt          = CNT_W'(1);
                point_next   = '0;
                expect_next  = '0;
                seq_len_next = '0;
            end
            else
            begin
                point_next  = point_acc;
                expect_next = expect_dec;
            end
        end

        // flag the last result of this byte
        for (int i = 0; i < MAX_RES; i++)
        begin
            res[i].run_last = (cnt == CNT_W'(i + 1));
        end
    end

    assign bundle.cnt = cnt;
    assign bundle.res = res;

    // Sequence state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_reg   <= '0;
            expect_reg  <= '0;
            seq_len_reg <= '0;
            failed_reg  <= 1'b0;
        end
        else if (take)
        begin
            point_reg   <= point_next;
            expect_reg  <= expect_next;
            seq_len_reg <= seq_len_next;
            failed_reg  <= failed_next;
        end
    end

endmodule

// ----- rtl/u8u16_serial.sv -----
// Result buffer and output register for the UTF-8 to UTF-16LE transcoder.
// Depends on u8u16_pkg; holds one byte's bundle, one result a cycle unless stalled.
module u8u16_serial (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  u8u16_pkg::res_bundle_t bundle,
    output logic                   can_load,
    output logic                   out_valid,
    input  logic                   out_stall,
    output u8u16_pkg::out_item_t   out_data
);
    import u8u16_pkg::*;

    out_item_t [MAX_RES-1:0] pend_reg, pend_next;
    logic [CNT_W-1:0]        pend_cnt_reg, pend_cnt_next;
    out_item_t               out_reg, out_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    out_moves;

    // Output register is free or being taken this cycle
    assign out_moves = !out_valid_reg || !out_stall;
    assign can_load  = (pend_cnt_reg == '0) ||
                       ((pend_cnt_reg == CNT_W'(1)) && out_moves);

    // Drain pending results into the output register, then refill
    always_comb
    begin
        pend_next      = pend_reg;
        pend_cnt_next  = pend_cnt_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        if (out_moves)
        begin
            if (pend_cnt_reg != '0)
            begin
                out_next       = pend_reg[0];
                out_valid_next = 1'b1;
                for (int i = 0; i < MAX_RES - 1; i++)
                begin
                    pend_next[i] = pend_reg[i + 1];
                end
                pend_cnt_next = pend_cnt_reg - CNT_W'(1);
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end

        if (load)
        begin
            pend_next     = bundle.res;
            pend_cnt_next = bundle.cnt;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_cnt_reg  <= pend_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ----- rtl/utf8_to_utf16le_transcoder.sv -----
// Top level of the UTF-8 to UTF-16LE transcoder.
// Depends on u8u16_pkg, u8u16_decode and u8u16_serial.
//
// Takes one UTF-8 byte per request on the byte channel and returns UTF-16
// code units, done markers and error reports on the unit channel, one per
// request. A byte is decoded in the cycle it is accepted and all of its
// results (up to three: a surrogate pair and a done marker) are captured in
// a small result buffer, then moved through the single output register.
// Unless the receiver stalls, that register gives one result per cycle and
// bytes with at most one result stream at one byte per cycle; a byte with
// more results holds off the next byte until they drain. A failed string is
// reported once and its remaining bytes are dropped until its terminator.
module utf8_to_utf16le_transcoder (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  byte_valid,
    output logic                  byte_stall,
    input  u8u16_pkg::in_item_t   byte_data,
    output logic                  unit_valid,
    input  logic                  unit_stall,
    output u8u16_pkg::out_item_t  unit_data
);
    import u8u16_pkg::*;

    res_bundle_t bundle;
    logic        can_load;
    logic        take;

    assign byte_stall = !can_load;
    assign take       = byte_valid && can_load;

    // Per-byte decode and sequence state
    u8u16_decode u_decode (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (take),
        .item   (byte_data),
        .bundle (bundle)
    );

    // Result buffer and output register
    u8u16_serial u_serial (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (take),
        .bundle    (bundle),
        .can_load  (can_load),
        .out_valid (unit_valid),
        .out_stall (unit_stall),
        .out_data  (unit_data)
    );

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the UTF-8 to UTF-16LE transcoder.
// Depends on u8u16_pkg and utf8_to_utf16le_transcoder; drives UTF-8 strings
// with random gaps and stalls and checks every result against a predictor.
module tb_top;
    import u8u16_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int TAIL_CYCLES  = 12;
    localparam int IDLE_PERCENT = 25;

    // Kinds of damage done to a random string
    typedef enum int {
        FLAW_OVERLONG,
        FLAW_SURROGATE,
        FLAW_TOO_BIG,
        FLAW_BAD_LEAD,
        FLAW_BAD_CONT,
        FLAW_TRUNCATE,
        FLAW_NOISE
    } flaw_t;

    logic      clk;
    logic      rst_n       = 1'b0;
    logic      byte_valid  = 1'b0;
    logic      byte_stall;
    in_item_t  byte_data   = '0;
    logic      unit_valid;
    logic      unit_stall  = 1'b0;
    out_item_t unit_data;

    // Decoder state as predicted
    logic [20:0] pt_partial;
    logic [1:0]  pt_remaining;
    logic [2:0]  pt_seq_len;
    logic        pt_failed;

    out_item_t step_results[$];
    out_item_t expected_units[$];

    logic steady_flow   = 1'b0;
    int   cycle_count   = 0;
    int   mismatches    = 0;
    int   bytes_sent    = 0;
    int   live_bytes    = 0;
    int   units_checked = 0;

    utf8_to_utf16le_transcoder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_data  (byte_data),
        .unit_valid (unit_valid),
        .unit_stall (unit_stall),
        .unit_data  (unit_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    function automatic void clear_decoder();
        pt_partial   = '0;
        pt_remaining = '0;
        pt_seq_len   = '0;
        pt_failed    = 1'b0;
    endfunction

    function automatic void add_result(input logic [15:0] unit, input kind_t k);
        out_item_t r;
        r.code_unit = unit;
        r.kind      = k;
        r.run_last  = 1'b0;
        step_results.insert(step_results.size(), r);
    endfunction

    // One error per string; discard the rest unless this byte ends it
    function automatic void report_error(input kind_t k, input logic ending);
        add_result(16'h0000, k);
        clear_decoder();
        if (!ending)
            pt_failed = 1'b1;
    endfunction

    function automatic void predict_byte(input in_item_t item);
        logic [7:0]  c;
        logic        eos;
        logic        ending;
        logic        bad;
        logic [20:0] cp;
        logic [20:0] offs;
        c      = item.in_byte;
        eos    = item.end_of_string;
        ending = eos || (c == 8'h00);
        step_results.delete();

        if (pt_failed)
        begin
            if (ending)
                clear_decoder();
        end
        else if (pt_remaining == 2'd0)
        begin
            // at a sequence boundary
            if (c == 8'h00)
            begin
                add_result(16'h0000, KIND_DONE);
                clear_decoder();
            end
            else if (c < 8'h80)
            begin
                add_result({8'h00, c}, KIND_UNIT);
                if (eos)
                begin
                    add_result(16'h0000, KIND_DONE);
                    clear_decoder();
                end
            end
            else if (c[7:5] == 3'b110 || c[7:4] == 4'b1110 || c[7:3] == 5'b11110)
            begin
                if (c[7:5] == 3'b110)
                begin
                    pt_partial   = {16'd0, c[4:0]};
                    pt_remaining = 2'd1;
                    pt_seq_len   = 3'd2;
                end
                else if (c[7:4] == 4'b1110)
                begin
                    pt_partial   = {17'd0, c[3:0]};
                    pt_remaining = 2'd2;
                    pt_seq_len   = 3'd3;
                end
                else
                begin
                    pt_partial   = {18'd0, c[2:0]};
                    pt_remaining = 2'd3;
                    pt_seq_len   = 3'd4;
                end
                // lead byte that is also the last byte: truncated
                if (eos)
                    report_error(KIND_BAD, 1'b1);
            end
            else
                report_error(KIND_BAD, ending);
        end
        else if (c == 8'h00 || c[7:6] != 2'b10)
            report_error(KIND_BAD, ending);
        else
        begin
            // continuation byte
            pt_partial   = {pt_partial[14:0], c[5:0]};
            pt_remaining = pt_remaining - 2'd1;
            if (pt_remaining == 2'd0)
            begin
                cp = pt_partial;
                if (pt_seq_len == 3'd2)
                    bad = cp < 21'h000080;
                else if (pt_seq_len == 3'd3)
                    bad = cp < 21'h000800;
                else
                    bad = cp < 21'h010000 || cp > 21'h10FFFF;

                if (bad)
                    report_error(KIND_BAD, eos);
                else if (cp >= 21'h00D800 && cp <= 21'h00DFFF)
                    report_error(KIND_SURR, eos);
                else
                begin
                    if (cp <= 21'h00FFFF)
                        add_result(cp[15:0], KIND_UNIT);
                    else
                    begin
                        offs = cp - 21'h010000;
                        add_result(16'hD800 | {6'd0, offs[19:10]}, KIND_UNIT);
                        add_result(16'hDC00 | {6'd0, offs[9:0]}, KIND_UNIT);
                    end
                    pt_partial = '0;
                    pt_seq_len = '0;
                    if (eos)
                    begin
                        add_result(16'h0000, KIND_DONE);
                        clear_decoder();
                    end
                end
            end
            else if (eos)
                report_error(KIND_BAD, 1'b1);
        end

        if (step_results.size() > 0)
            step_results[step_results.size() - 1].run_last = 1'b1;
        foreach (step_results[i])
            expected_units.insert(expected_units.size(), step_results[i]);
    endfunction

    // ---------------------------------------------------------------
    // Byte sender
    // ---------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic eos);
        in_item_t item;
        item.in_byte       = b;
        item.end_of_string = eos;
        if (!steady_flow)
        begin
            while ($urandom_range(99) < IDLE_PERCENT)
            begin
                byte_valid <= 1'b0;
                @(posedge clk);
            end
        end
        byte_valid <= 1'b1;
        byte_data  <= item;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        bytes_sent++;
        if (!pt_failed)
            live_bytes++;
        predict_byte(item);
    endtask

    // Hold off until every predicted result is back, then let the pipe settle
    task automatic wait_drained();
        byte_valid <= 1'b0;
        while (expected_units.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // UTF-8 form of a point at a chosen length, first byte most significant
    function automatic logic [31:0] utf8_bytes(input logic [20:0] cp, input int len);
        case (len)
            1:       return {24'd0, 1'b0, cp[6:0]};
            2:       return {16'd0, 3'b110, cp[10:6], 2'b10, cp[5:0]};
            3:       return {8'd0, 4'b1110, cp[15:12], 2'b10, cp[11:6], 2'b10, cp[5:0]};
            default: return {5'b11110, cp[20:18], 2'b10, cp[17:12], 2'b10, cp[11:6],
                             2'b10, cp[5:0]};
        endcase
    endfunction

    // One string of random points, sometimes with a single flaw in it
    task automatic send_random_string();
        logic [7:0]  seq_bytes[$];
        logic [20:0] cp;
        logic [31:0] word;
        logic [7:0]  b;
        int          n_points;
        int          flaw_at;
        int          len;
        int          keep;
        int          first;
        logic        cut_short;
        logic        flag_end;
        flaw_t       flaw;
        n_points  = $urandom_range(1, 6);
        flaw_at   = ($urandom_range(99) < 30) ? $urandom_range(0, n_points - 1) : -1;
        flaw      = flaw_t'($urandom_range(0, 6));
        cut_short = 1'b0;

        for (int i = 0; i < n_points && !cut_short; i++)
        begin
            case ($urandom_range(3))
                0: begin cp = 21'($urandom_range(1, 'h7F));          len = 1; end
                1: begin cp = 21'($urandom_range('h80, 'h7FF));      len = 2; end
                2: begin cp = 21'($urandom_range('h800, 'hFFFF));    len = 3; end
                default: begin cp = 21'($urandom_range('h10000, 'h10FFFF)); len = 4; end
            endcase
            if (len == 3 && cp >= 21'h00D800 && cp <= 21'h00DFFF)
                cp = cp - 21'h000800;

            if (i == flaw_at)
            begin
                case (flaw)
                    FLAW_OVERLONG:
                    begin
                        len = $urandom_range(2, 4);
                        cp  = (len == 2) ? 21'($urandom_range(0, 'h7F)) :
                              (len == 3) ? 21'($urandom_range(0, 'h7FF)) :
                                           21'($urandom_range(0, 'hFFFF));
                    end
                    FLAW_SURROGATE:
                    begin
                        len = 3;
                        cp  = 21'($urandom_range('hD800, 'hDFFF));
                    end
                    FLAW_TOO_BIG:
                    begin
                        len = 4;
                        cp  = 21'($urandom_range('h110000, 'h1FFFFF));
                    end
                    FLAW_BAD_CONT, FLAW_TRUNCATE:
                    begin
                        if (len == 1)
                        begin
                            len = 2;
                            cp  = 21'($urandom_range('h80, 'h7FF));
                        end
                    end
                    default: ;
                endcase
            end

            first = seq_bytes.size();
            word  = utf8_bytes(cp, len);
            for (int j = len - 1; j >= 0; j--)
                seq_bytes.insert(seq_bytes.size(), word[8 * j +: 8]);

            if (i == flaw_at)
            begin
                case (flaw)
                    FLAW_BAD_LEAD:
                    begin
                        b = ($urandom_range(1)) ? 8'($urandom_range('h80, 'hBF)) :
                                                  8'($urandom_range('hF8, 'hFF));
                        seq_bytes[first] = b;
                    end
                    FLAW_BAD_CONT:
                    begin
                        b = 8'($urandom_range(255));
                        while (b[7:6] == 2'b10)
                            b = 8'($urandom_range(255));
                        seq_bytes[first + $urandom_range(1, len - 1)] = b;
                    end
                    FLAW_TRUNCATE:
                    begin
                        keep = $urandom_range(1, len - 1);
                        while (seq_bytes.size() > first + keep)
                            void'(seq_bytes.pop_back());
                        cut_short = 1'b1;
                    end
                    FLAW_NOISE:
                    begin
                        repeat ($urandom_range(1, 4))
                            seq_bytes.insert(seq_bytes.size(), 8'($urandom_range(255)));
                    end
                    default: ;
                endcase
            end
        end

        // end either with the flag on the last byte or with a zero byte
        flag_end = 1'($urandom_range(1));
        if (!flag_end)
            seq_bytes.insert(seq_bytes.size(), 8'h00);
        foreach (seq_bytes[k])
        begin
            if (k == seq_bytes.size() - 1)
                send_byte(seq_bytes[k], flag_end ? 1'b1 : 1'($urandom_range(1)));
            else
                send_byte(seq_bytes[k], 1'b0);
        end
    endtask

    // ---------------------------------------------------------------
    // Test tasks
    // ---------------------------------------------------------------
    task automatic test_ascii_and_terminators();
        send_byte(8'h7F, 1'b0);
        send_byte(8'h01, 1'b1);     // end flag at a boundary
        send_byte(8'h00, 1'b1);     // empty string, zero terminator
    endtask

    task automatic test_multibyte_points();
        send_byte(8'hDF, 1'b0);     // largest 2-byte point
        send_byte(8'hBF, 1'b0);
        send_byte(8'hF0, 1'b0);     // smallest 4-byte point: pair then done
        send_byte(8'h90, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b1);
    endtask

    task automatic test_malformed_strings();
        // stray continuation as lead, rest dropped up to the zero
        send_byte(8'h80, 1'b0);
        send_byte(8'h00, 1'b0);
        // 11111xxx lead on the last byte
        send_byte(8'hF8, 1'b1);
        // overlong 3-byte form, then a dropped ending byte
        send_byte(8'hE0, 1'b0);
        send_byte(8'h9F, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'h41, 1'b1);
        // point above the last plane
        send_byte(8'hF4, 1'b0);
        send_byte(8'h90, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b1);
        // surrogate code point, string closed by a zero
        send_byte(8'hED, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'h00, 1'b0);
        // lead byte that ends the string
        send_byte(8'hE1, 1'b1);
        // zero inside a sequence
        send_byte(8'hC2, 1'b0);
        send_byte(8'h00, 1'b0);
    endtask

    task automatic test_random_strings(input int target);
        int stop_at;
        stop_at = bytes_sent + target;
        while (bytes_sent < stop_at)
            send_random_string();
    endtask

    // Full rate on both sides for a while
    task automatic test_steady_stream(input int target);
        steady_flow = 1'b1;
        test_random_strings(target);
        steady_flow = 1'b0;
    endtask

    // ---------------------------------------------------------------
    // Receiver stalls and result checking
    // ---------------------------------------------------------------
    always @(posedge clk)
        unit_stall <= !steady_flow && ($urandom_range(99) < IDLE_PERCENT);

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && unit_valid && !unit_stall)
        begin
            units_checked++;
            if (expected_units.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: unit=%h kind=%0d last=%b",
                             unit_data.code_unit, unit_data.kind, unit_data.run_last);
            end
            else
            begin
                want = expected_units.pop_front();
                if (unit_data.code_unit !== want.code_unit || unit_data.kind !== want.kind
                    || unit_data.run_last !== want.run_last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: got %h/%0d/%b want %h/%0d/%b",
                                 unit_data.code_unit, unit_data.kind, unit_data.run_last,
                                 want.code_unit, want.kind, want.run_last);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_units.size());
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial
    begin
        clear_decoder();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_ascii_and_terminators();
        test_multibyte_points();
        wait_drained();
        test_malformed_strings();
        wait_drained();
        test_random_strings(80);
        wait_drained();
        test_steady_stream(60);
        test_random_strings(80);
        wait_drained();

        if (expected_units.size() != 0)
        begin
            mismatches += expected_units.size();
            $display("%0d expected results never arrived", expected_units.size());
        end
        $display("sent %0d UTF-8 bytes (%0d decoded, rest dropped after errors)",
                 bytes_sent, live_bytes);
        $display("checked %0d results incl. surrogate pairs, done markers and errors",
                 units_checked);
        if (mismatches == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/u8u16_pkg.sv
rtl/u8u16_decode.sv
rtl/u8u16_serial.sv
rtl/utf8_to_utf16le_transcoder.sv
sim/tb_top.sv
